### rtl/cmf_pkg.sv
package cmf_pkg;

   localparam int PIX_W       = 8;
   localparam int CFG_W       = 11;
   localparam int SUM_W       = 11;
   localparam int CNT_W       = 3;
   localparam int RECIP_SHIFT = 16;
   localparam int PROD_W      = SUM_W + RECIP_SHIFT;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // reciprocals rounded up; exact for sums up to five full-scale pixels
   localparam logic [RECIP_SHIFT-1:0] RECIP_3 = 16'd21846;
   localparam logic [RECIP_SHIFT-1:0] RECIP_4 = 16'd16384;
   localparam logic [RECIP_SHIFT-1:0] RECIP_5 = 16'd13108;

   localparam logic [CNT_W-1:0] COUNT_3 = 3'd3;
   localparam logic [CNT_W-1:0] COUNT_5 = 3'd5;

   typedef struct packed {
      logic             col0;
      logic             has_up;
      logic             has_down;
      logic             has_right;
      logic             parity;
      logic             last;
      logic [PIX_W-1:0] down;
      logic [PIX_W-1:0] cap0;
      logic [PIX_W-1:0] cap1;
   } cmf_stage_type;

   function automatic logic [PIX_W-1:0] cmf_mean(input logic [SUM_W-1:0] sum,
                                                 input logic [CNT_W-1:0] count);
      logic [RECIP_SHIFT-1:0] recip;
      logic [PROD_W-1:0]      prod;
      case (count)
         COUNT_3: recip = RECIP_3;
         COUNT_5: recip = RECIP_5;
         default: recip = RECIP_4;
      endcase
      prod = PROD_W'(sum) * PROD_W'(recip);
      return prod[RECIP_SHIFT +: PIX_W];
   endfunction

endpackage

### rtl/cmf_ram.sv
module cmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/cmf_ctrl.sv
module cmf_ctrl #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_tuser,
   input  logic [cmf_pkg::PIX_W-1:0]    req_tdata,
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [cmf_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                         take_ok,
   output logic                         s1_valid,
   output cmf_pkg::cmf_stage_type       s1_data,
   output logic [1:0]                   bank_we,
   output logic [COL_W-1:0]             bank_waddr,
   output logic [cmf_pkg::PIX_W-1:0]    bank_wdata,
   output logic                         bank_rd_en,
   output logic [1:0][COL_W-1:0]        bank_raddr
);
   import cmf_pkg::*;

   typedef enum logic [1:0] {PH_FILL, PH_RUN, PH_DRAIN} phase_type;

   localparam int RESET_W = (5 > MAX_WIDTH) ? MAX_WIDTH : 5;
   localparam int RESET_H = (5 > MAX_HEIGHT) ? MAX_HEIGHT : 5;

   phase_type        phase_ff, phase_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] last_col_ff, last_col_in;
   logic [ROW_W-1:0] last_row_ff, last_row_in;
   logic [PIX_W-1:0] cap0_ff, cap0_in;
   logic [PIX_W-1:0] cap1_ff, cap1_in;
   logic             s1_valid_ff, s1_valid_in;
   cmf_stage_type    s1_ff, s1_in;

   logic accept;
   logic is_pix;
   logic produce;
   logic col_last;
   logic capture;

   assign req_tready = !s1_valid_ff || take_ok;
   assign accept     = req_tvalid && req_tready;
   assign is_pix     = (req_tuser == OP_PIXEL);
   assign col_last   = (col_ff == last_col_ff);
   assign produce    = accept && (((phase_ff == PH_RUN) && is_pix) ||
                                  ((phase_ff == PH_DRAIN) && !is_pix));
   assign capture    = accept && is_pix && ((phase_ff == PH_FILL) || (phase_ff == PH_RUN));

   always_comb begin
      bank_we[0] = capture && ((phase_ff == PH_FILL) ||
                               ((phase_ff == PH_RUN) && row_ff[0]));
      bank_we[1] = capture && (phase_ff == PH_RUN) && !row_ff[0];
      bank_waddr = col_ff;
      bank_wdata = req_tdata;
      bank_rd_en = produce;
      bank_raddr[0] = row_ff[0] ? col_ff : COL_W'(col_ff + 1'b1);
      bank_raddr[1] = row_ff[0] ? COL_W'(col_ff + 1'b1) : col_ff;
   end

   always_comb begin
      phase_in    = phase_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      cap0_in     = cap0_ff;
      cap1_in     = cap1_ff;

      if (capture && (col_ff == COL_W'(0))) begin
         cap0_in = req_tdata;
      end
      if (capture && (col_ff == COL_W'(1))) begin
         cap1_in = req_tdata;
      end

      case (phase_ff)
         PH_FILL: begin
            if (accept && is_pix) begin
               if (col_last) begin
                  phase_in = PH_RUN;
                  col_in   = '0;
                  row_in   = '0;
               end else begin
                  col_in = COL_W'(col_ff + 1'b1);
               end
            end
         end
         PH_RUN: begin
            if (accept && is_pix) begin
               if (col_last) begin
                  col_in = '0;
                  row_in = ROW_W'(row_ff + 1'b1);
                  if (ROW_W'(row_ff + 1'b1) == last_row_ff) begin
                     phase_in = PH_DRAIN;
                  end
               end else begin
                  col_in = COL_W'(col_ff + 1'b1);
               end
            end
         end
         PH_DRAIN: begin
            if (accept && !is_pix) begin
               if (col_last) begin
                  phase_in = PH_FILL;
                  col_in   = '0;
                  row_in   = '0;
               end else begin
                  col_in = COL_W'(col_ff + 1'b1);
               end
            end
         end
         default: begin
            phase_in = PH_FILL;
         end
      endcase

      if (csr_we) begin
         phase_in = PH_FILL;
         col_in   = '0;
         row_in   = '0;
         if (csr_index == REG_WIDTH) begin
            if (32'(csr_wdata) < 2) begin
               last_col_in = COL_W'(1);
            end else if (32'(csr_wdata) > MAX_WIDTH) begin
               last_col_in = COL_W'(MAX_WIDTH - 1);
            end else begin
               last_col_in = COL_W'(csr_wdata - 1'b1);
            end
         end
         if (csr_index == REG_HEIGHT) begin
            if (32'(csr_wdata) < 2) begin
               last_row_in = ROW_W'(1);
            end else if (32'(csr_wdata) > MAX_HEIGHT) begin
               last_row_in = ROW_W'(MAX_HEIGHT - 1);
            end else begin
               last_row_in = ROW_W'(csr_wdata - 1'b1);
            end
         end
      end
   end

   always_comb begin
      s1_in           = s1_ff;
      s1_valid_in     = s1_valid_ff;
      if (s1_valid_ff && take_ok) begin
         s1_valid_in = 1'b0;
      end
      if (produce) begin
         s1_valid_in        = 1'b1;
         s1_in.col0         = (col_ff == '0);
         s1_in.has_up       = (row_ff != '0);
         s1_in.has_down     = (phase_ff == PH_RUN);
         s1_in.has_right    = !col_last;
         s1_in.parity       = row_ff[0];
         s1_in.last         = (phase_ff == PH_DRAIN) && col_last;
         s1_in.down         = req_tdata;
         s1_in.cap0         = cap0_ff;
         s1_in.cap1         = cap1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FILL;
         col_ff      <= '0;
         row_ff      <= '0;
         last_col_ff <= COL_W'(RESET_W - 1);
         last_row_ff <= ROW_W'(RESET_H - 1);
         s1_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
         s1_valid_ff <= s1_valid_in;
      end
      cap0_ff <= cap0_in;
      cap1_ff <= cap1_in;
      s1_ff   <= s1_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_ff;

endmodule

### rtl/cmf_calc.sv
module cmf_calc (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      s1_valid,
   input  cmf_pkg::cmf_stage_type    s1_data,
   input  logic [cmf_pkg::PIX_W-1:0] rd_data0,
   input  logic [cmf_pkg::PIX_W-1:0] rd_data1,
   output logic                      take_ok,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [cmf_pkg::PIX_W-1:0] rsp_tdata,
   output logic                      rsp_tlast
);
   import cmf_pkg::*;

   logic [PIX_W-1:0] win_l_ff, win_l_in;
   logic [PIX_W-1:0] win_c_ff, win_c_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             load;
   logic [PIX_W-1:0] up;
   logic [PIX_W-1:0] right_mem;
   logic [PIX_W-1:0] centre;
   logic [PIX_W-1:0] right;
   logic [SUM_W-1:0] sum;
   logic [CNT_W-1:0] count;

   assign take_ok = !rsp_valid_ff || rsp_tready;
   assign load    = s1_valid && take_ok;

   always_comb begin
      up        = s1_data.parity ? rd_data0 : rd_data1;
      right_mem = s1_data.parity ? rd_data1 : rd_data0;
      centre    = s1_data.col0 ? s1_data.cap0 : win_c_ff;
      right     = s1_data.col0 ? s1_data.cap1 : right_mem;

      sum = SUM_W'(centre)
          + (s1_data.has_up    ? SUM_W'(up)           : '0)
          + (s1_data.has_down  ? SUM_W'(s1_data.down) : '0)
          + (!s1_data.col0     ? SUM_W'(win_l_ff)     : '0)
          + (s1_data.has_right ? SUM_W'(right)        : '0);
      count = CNT_W'(1)
            + CNT_W'(s1_data.has_up)
            + CNT_W'(s1_data.has_down)
            + CNT_W'(!s1_data.col0)
            + CNT_W'(s1_data.has_right);

      win_l_in     = win_l_ff;
      win_c_in     = win_c_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load) begin
         win_l_in     = centre;
         win_c_in     = right;
         rsp_data_in  = cmf_mean(sum, count);
         rsp_last_in  = s1_data.last;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      win_l_ff    <= win_l_in;
      win_c_ff    <= win_c_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

### rtl/cross_mean_filter_edge_aware.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_tvalid/req_tready  tuser: op; tdata: pixel
// rsp_      out        rsp_tvalid/rsp_tready  tdata: filtered; tlast: frame_end
// csr_      in         csr_we                 csr_index, csr_wdata
//
// One transaction per clock while req_tready is high; a result follows the pixel
// below it (or the drain transaction) once taken: the line-buffer read into the
// stage register, then the sum and reciprocal multiply into the output register.
// Synchronous reset clears control state; the two line-buffer RAMs are not cleared.
// With rsp_tready low one result waits in the output register and one more in
// the read stage; req_tready drops only when both are full.
module cross_mean_filter_edge_aware #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      req_tuser,   // [0] op
   input  logic [cmf_pkg::PIX_W-1:0] req_tdata,   // [7:0] pixel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [cmf_pkg::PIX_W-1:0] rsp_tdata,   // [7:0] filtered
   output logic                      rsp_tlast,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [cmf_pkg::CFG_W-1:0] csr_wdata
);
   import cmf_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic                    take_ok;
   logic                    s1_valid;
   cmf_stage_type           s1_data;
   logic [1:0]              bank_we;
   logic [COL_W-1:0]        bank_waddr;
   logic [PIX_W-1:0]        bank_wdata;
   logic                    bank_rd_en;
   logic [1:0][COL_W-1:0]   bank_raddr;
   logic [1:0][PIX_W-1:0]   bank_rdata;

   cmf_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .take_ok    (take_ok),
      .s1_valid   (s1_valid),
      .s1_data    (s1_data),
      .bank_we    (bank_we),
      .bank_waddr (bank_waddr),
      .bank_wdata (bank_wdata),
      .bank_rd_en (bank_rd_en),
      .bank_raddr (bank_raddr)
   );

   for (genvar b = 0; b < 2; b++) begin : g_bank
      cmf_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (bank_waddr),
         .wr_data (bank_wdata),
         .rd_en   (bank_rd_en),
         .rd_addr (bank_raddr[b]),
         .rd_data (bank_rdata[b])
      );
   end

   cmf_calc u_calc (
      .clock      (clock),
      .reset      (reset),
      .s1_valid   (s1_valid),
      .s1_data    (s1_data),
      .rd_data0   (bank_rdata[0]),
      .rd_data1   (bank_rdata[1]),
      .take_ok    (take_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### verif/cross_mean_filter_edge_aware_checker.sv
`timescale 1ns / 1ps

module cross_mean_filter_edge_aware_checker #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic                      req_tuser,   // [0] op
   input  logic [cmf_pkg::PIX_W-1:0] req_tdata,   // [7:0] pixel
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [cmf_pkg::PIX_W-1:0] rsp_tdata,   // [7:0] filtered
   input  logic                      rsp_tlast,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [cmf_pkg::CFG_W-1:0] csr_wdata,
   output int                        error_count,
   output int                        pending
);

   import cmf_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] filtered;
      logic             frame_end;
   } mean_result_type;

   mean_result_type  expected_means[$];
   logic [PIX_W-1:0] row_store[0:2*MAX_WIDTH-1];
   logic [CFG_W-1:0] width_cfg;
   logic [CFG_W-1:0] height_cfg;
   int unsigned      seen_count;
   int unsigned      out_col;
   int unsigned      out_row;

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned maxv);
      if (v < 2) return 2;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int unsigned row_slot(input int unsigned row, input int unsigned col);
      return ((row % 2) * MAX_WIDTH + col) % (2 * MAX_WIDTH);
   endfunction

   function automatic logic [PIX_W-1:0] cross_mean(input bit down_ok, input int unsigned down_px,
                                                   input int unsigned up_px, input int unsigned w);
      int unsigned sum;
      int unsigned n;
      sum = row_store[row_slot(out_row, out_col)];
      n   = 1;
      if (out_row > 0) begin
         sum += up_px;
         n++;
      end
      if (down_ok) begin
         sum += down_px;
         n++;
      end
      if (out_col > 0) begin
         sum += row_store[row_slot(out_row, out_col - 1)];
         n++;
      end
      if (out_col + 1 < w) begin
         sum += row_store[row_slot(out_row, out_col + 1)];
         n++;
      end
      return PIX_W'(sum / n);
   endfunction

   task automatic restart_frame();
      seen_count = 0;
      out_col    = 0;
      out_row    = 0;
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR: %s", $time, msg);
      error_count++;
   endtask

   task automatic advance_filter(input logic op, input logic [PIX_W-1:0] px);
      int unsigned     w;
      int unsigned     h;
      int unsigned     total;
      int unsigned     up_slot;
      int unsigned     up_px;
      mean_result_type res;
      w     = clamp_dim(width_cfg, MAX_WIDTH);
      h     = clamp_dim(height_cfg, MAX_HEIGHT);
      total = w * h;
      if (op == OP_PIXEL) begin
         if (seen_count < w) begin
            row_store[row_slot(0, seen_count)] = px;
            seen_count++;
         end else if (seen_count < total) begin
            up_slot = row_slot(out_row + 1, out_col);
            up_px   = row_store[up_slot];
            res.filtered  = cross_mean(1'b1, px, up_px, w);
            res.frame_end = 1'b0;
            row_store[up_slot] = px;
            seen_count++;
            if (out_col + 1 >= w) begin
               out_col = 0;
               out_row++;
            end else begin
               out_col++;
            end
            expected_means.push_back(res);
         end
      end else if (seen_count >= total) begin
         up_px = 0;
         if (out_row > 0) up_px = row_store[row_slot(out_row + 1, out_col)];
         res.filtered  = cross_mean(1'b0, 0, up_px, w);
         res.frame_end = (out_col + 1 >= w);
         if (res.frame_end) restart_frame();
         else out_col++;
         expected_means.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      mean_result_type head;
      if (reset) begin
         width_cfg  = 11'd5;
         height_cfg = 11'd5;
         restart_frame();
         expected_means.delete();
         error_count = 0;
         pending <= 0;
      end else begin
         if (csr_we) begin
            if (csr_index == REG_WIDTH) width_cfg = csr_wdata;
            else height_cfg = csr_wdata;
            restart_frame();
         end
         if (req_tvalid && req_tready) advance_filter(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_means.size() == 0) begin
               report_mismatch($sformatf("unexpected result filtered=%0d frame_end=%0b",
                                         rsp_tdata, rsp_tlast));
            end else begin
               head = expected_means.pop_front();
               if (rsp_tdata !== head.filtered)
                  report_mismatch($sformatf("filtered got %0d want %0d",
                                            rsp_tdata, head.filtered));
               if (rsp_tlast !== head.frame_end)
                  report_mismatch($sformatf("frame_end got %0b want %0b",
                                            rsp_tlast, head.frame_end));
            end
         end
         pending <= expected_means.size();
      end
   end

endmodule

### verif/cross_mean_filter_edge_aware_tb.sv
`timescale 1ns / 1ps

module cross_mean_filter_edge_aware_tb;

   import cmf_pkg::*;

   localparam int SETTLE_CYCLES = 8;
   localparam int RUN_LIMIT     = 1000000;
   localparam int TARGET_ITEMS  = 1150;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tuser  = 1'b0;
   logic [PIX_W-1:0] req_tdata  = '0;
   logic             rsp_tready = 1'b0;
   logic             csr_we     = 1'b0;
   logic             csr_index  = 1'b0;
   logic [CFG_W-1:0] csr_wdata  = '0;

   logic             req_tready;
   logic             rsp_tvalid;
   logic [PIX_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   int error_count;
   int pending;
   int cycle_count = 0;
   int burst_left  = 0;
   int sent_items  = 0;
   int rx_mode     = 0;
   int mode_left   = 0;
   int unsigned eff_w = 5;
   int unsigned eff_h = 5;

   cross_mean_filter_edge_aware u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   cross_mean_filter_edge_aware_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (error_count),
      .pending     (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: alternate between always ready, light stalls and heavy stalls
   always @(posedge clock) begin
      if (mode_left == 0) begin
         rx_mode   <= $urandom_range(0, 2);
         mode_left <= $urandom_range(20, 200);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
      if (v < 2) return 2;
      if (v > 1024) return 1024;
      return v;
   endfunction

   task automatic push_item(input logic op, input logic [PIX_W-1:0] px);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // hold off until every result is back and the pipeline has emptied
   task automatic settle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input bit do_w, input bit do_h,
                            input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
      settle();
      if (do_w) begin
         csr_we    <= 1'b1;
         csr_index <= REG_WIDTH;
         csr_wdata <= wv;
         eff_w = clamp_dim(wv);
         @(posedge clock);
      end
      if (do_h) begin
         csr_we    <= 1'b1;
         csr_index <= REG_HEIGHT;
         csr_wdata <= hv;
         eff_h = clamp_dim(hv);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // pixels of one frame with some noise; drain only when the frame is complete
   task automatic run_frame(input int unsigned pix_count);
      int unsigned total;
      int unsigned k;
      total = eff_w * eff_h;
      for (k = 0; k < pix_count; k++) begin
         if ($urandom_range(0, 39) == 0) push_item(OP_DRAIN, PIX_W'($urandom));
         push_item(OP_PIXEL, PIX_W'($urandom));
         sent_items++;
      end
      if (pix_count == total) begin
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) push_item(OP_PIXEL, PIX_W'($urandom));
         for (k = 0; k < eff_w; k++) begin
            push_item(OP_DRAIN, PIX_W'($urandom));
            sent_items++;
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_item(OP_DRAIN, PIX_W'($urandom));
      end
   endtask

   initial begin
      int               k;
      int               frames;
      int               f;
      bit               big_done;
      logic [CFG_W-1:0] wv;
      logic [CFG_W-1:0] hv;
      big_done = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // drain on an empty frame
      push_item(OP_DRAIN, 8'hA5);

      // full-scale 2x2 frame, then a surplus drain
      configure(1, 1, 11'd2, 11'd2);
      for (k = 0; k < 4; k++) push_item(OP_PIXEL, 8'hFF);
      push_item(OP_DRAIN, 8'h00);
      push_item(OP_DRAIN, 8'hFF);
      push_item(OP_DRAIN, 8'h5A);

      // next frame without reconfiguring, with a pixel after the frame is full
      push_item(OP_PIXEL, 8'h00);
      push_item(OP_PIXEL, 8'hFF);
      push_item(OP_PIXEL, 8'hFF);
      push_item(OP_PIXEL, 8'h00);
      push_item(OP_PIXEL, 8'h77);
      push_item(OP_DRAIN, 8'h00);
      push_item(OP_DRAIN, 8'h00);

      // sizes below range clamp to two, with an early drain
      configure(1, 1, 11'd0, 11'd1);
      push_item(OP_PIXEL, 8'h01);
      push_item(OP_PIXEL, 8'h80);
      push_item(OP_PIXEL, 8'h7F);
      push_item(OP_DRAIN, 8'hFF);
      push_item(OP_PIXEL, 8'hFE);
      push_item(OP_DRAIN, 8'h00);
      push_item(OP_DRAIN, 8'h00);

      sent_items = 0;
      while (sent_items < TARGET_ITEMS) begin
         if (!big_done && sent_items > 100) begin
            // widest frame: full first row and the start of the second
            wv = ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'd2047;
            hv = ($urandom_range(0, 1) == 0) ? 11'd2 : 11'd1;
            configure(1, 1, wv, hv);
            run_frame(eff_w + $urandom_range(16, 40));
            big_done = 1;
         end else if ($urandom_range(0, 7) == 0) begin
            // out-of-range or extreme register values
            if ($urandom_range(0, 1) == 0) begin
               wv = 11'($urandom_range(0, 1));
               hv = 11'($urandom_range(2, 6));
            end else begin
               wv = 11'($urandom_range(2, 4));
               case ($urandom_range(0, 4))
                  0:       hv = 11'd0;
                  1:       hv = 11'd1;
                  2:       hv = 11'd1024;
                  3:       hv = 11'd1025;
                  default: hv = 11'd2047;
               endcase
            end
            configure(1, 1, wv, hv);
            if (eff_h > 8) run_frame(eff_w * $urandom_range(2, 8));
            else run_frame(eff_w * eff_h);
         end else begin
            wv = 11'($urandom_range(2, 9));
            hv = 11'($urandom_range(2, 6));
            case ($urandom_range(0, 3))
               0:       configure(1, 0, wv, hv);
               1:       configure(0, 1, wv, hv);
               default: configure(1, 1, wv, hv);
            endcase
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
               if (f == frames - 1 && $urandom_range(0, 4) == 0)
                  run_frame($urandom_range(1, eff_w * eff_h - 1));
               else
                  run_frame(eff_w * eff_h);
               if ($urandom_range(0, 3) == 0) settle();
            end
         end
      end

      settle();
      repeat (32) @(posedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
